### src/ulbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulbe_pkg
// Shared constants for the console line buffer with erase.
// ----------------------------------------------------------------------------
package ulbe_pkg;

    localparam int BYTE_W = 8;
    localparam int LINE_MAX_DEF = 63;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] EOL_RESET = 8'd10;
    localparam logic [BYTE_W-1:0] ERASE_RESET = 8'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_EOL_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CODE = 1'b1;

endpackage

### src/ulbe_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulbe_store
// Line store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ulbe_store #(
    parameter int DEPTH = ulbe_pkg::LINE_MAX_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [ulbe_pkg::BYTE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [ulbe_pkg::BYTE_W-1:0] rdata
);
    import ulbe_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/ulbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulbe_ctrl
// Sequencer: fill counter, code compare, and the replay walk over the store.
// ----------------------------------------------------------------------------
module ulbe_ctrl #(
    parameter int LINE_MAX = ulbe_pkg::LINE_MAX_DEF,
    parameter int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
    parameter int CNT_W = $clog2(LINE_MAX + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ulbe_pkg::BYTE_W-1:0] eol_code,
    input  logic [ulbe_pkg::BYTE_W-1:0] erase_code,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ulbe_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ulbe_pkg::BYTE_W-1:0] out_char,
    output logic                        last,
    output logic                        st_we,
    output logic [ADDR_W-1:0]           st_waddr,
    output logic [ulbe_pkg::BYTE_W-1:0] st_wdata,
    output logic [ADDR_W-1:0]           st_raddr,
    input  logic [ulbe_pkg::BYTE_W-1:0] st_rdata
);
    import ulbe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND,
        ST_LAST
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_char_reg, out_char_next;
    logic              last_reg, last_next;
    logic              in_xfer;
    logic              out_xfer;
    logic              is_eol;
    logic              is_erase;
    logic              has_room;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign is_eol   = (rx_byte == eol_code);
    assign is_erase = (rx_byte == erase_code);
    assign has_room = (count_reg < CNT_W'(LINE_MAX));

    assign st_we    = in_xfer && !is_eol && !is_erase && has_room;
    assign st_waddr = count_reg[ADDR_W-1:0];
    assign st_wdata = rx_byte;
    assign st_raddr = (state_reg == ST_IDLE) ? '0 : idx_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    priority if (is_eol)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = eol_code;
                            last_next      = 1'b1;
                            state_next     = ST_LAST;
                        end
                        else
                        begin
                            idx_next   = CNT_W'(1);
                            state_next = ST_FETCH;
                        end
                    end
                    else if (is_erase)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg;
                    end
                end
            end
            ST_FETCH:
            begin
                out_valid_next = 1'b1;
                out_char_next  = st_rdata;
                last_next      = 1'b0;
                state_next     = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_xfer)
                begin
                    if (idx_reg == count_reg)
                    begin
                        out_char_next = eol_code;
                        last_next     = 1'b1;
                        state_next    = ST_LAST;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        idx_next       = idx_reg + CNT_W'(1);
                        state_next     = ST_FETCH;
                    end
                end
            end
            ST_LAST:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    last_next      = 1'b0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

### src/uart_line_buffer_with_erase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_buffer_with_erase
// Console line buffer: collects received bytes, handles erase, replays lines.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per
// transfer. A plain byte is appended to the line, and is dropped
// when the line already holds LINE_MAX characters. The erase code removes the
// last character and does nothing on an empty line.
// The end-of-line code starts a replay on the output channel (out_valid,
// out_ready, out_char, last): the stored characters oldest first, then the
// end-of-line code with last set, after which the line is empty.
// Each replayed character is first read from the store with registered data,
// then held in the output register until the receiver takes it. in_ready
// stays low for the whole replay; a stall on out_ready simply holds the
// current character and the sequencer. Reset empties the line and sets the
// end-of-line code to 10 and the erase code to 8. The codes are written
// through cfg_we, cfg_index and cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. If both codes are
// equal, end of line wins.
// ----------------------------------------------------------------------------
module uart_line_buffer_with_erase #(
    parameter int LINE_MAX = ulbe_pkg::LINE_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ulbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ulbe_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ulbe_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ulbe_pkg::BYTE_W-1:0]    out_char,
    output logic                           last
);
    import ulbe_pkg::*;

    localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CNT_W = $clog2(LINE_MAX + 1);

    logic [BYTE_W-1:0] eol_code_reg;
    logic [BYTE_W-1:0] erase_code_reg;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [BYTE_W-1:0] st_wdata;
    logic [ADDR_W-1:0] st_raddr;
    logic [BYTE_W-1:0] st_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eol_code_reg   <= EOL_RESET;
            erase_code_reg <= ERASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EOL_CODE:   eol_code_reg   <= cfg_data;
                CFG_ERASE_CODE: erase_code_reg <= cfg_data;
                default:        eol_code_reg   <= eol_code_reg;
            endcase
        end
    end

    ulbe_store #(
        .DEPTH  (LINE_MAX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    ulbe_ctrl #(
        .LINE_MAX (LINE_MAX),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .eol_code   (eol_code_reg),
        .erase_code (erase_code_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last       (last),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .st_raddr   (st_raddr),
        .st_rdata   (st_rdata)
    );

endmodule
